[src/ordered_circular_deque_unit_macros.svh]
// assertion macros for the ordered circular deque unit
// no dependencies
`ifndef ORDERED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define ORDERED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define OCD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define OCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/ocd_pkg.sv]
// shared types and constants of the ordered circular deque unit
// no dependencies
package ocd_pkg;
	localparam int CAPACITY_DEF   = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FUNC_W  = 4;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 10;
	localparam int LEN_W   = 11;

	typedef enum logic [3:0] {
		F_PUSH_TAIL = 4'd0, F_PUSH_FRONT = 4'd1, F_POP_FRONT = 4'd2,
		F_POP_BACK = 4'd3, F_READ = 4'd4, F_WRITE = 4'd5, F_CHECK = 4'd6,
		F_SEARCH = 4'd7, F_CLEAR = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		ORD_NONE = 2'd0, ORD_ASC = 2'd1, ORD_DESC = 2'd2
	} order_t;

	typedef enum logic [1:0] {
		ERR_OK = 2'd0, ERR_FULL = 2'd1, ERR_EMPTY = 2'd2, ERR_RANGE = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_RD, ST_SCAN, ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture input item
		logic decode;     // evaluate checks, issue first access
		logic scan_step;  // one walk step
		logic finish;     // load result registers
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_rd;    // item needs a stored neighbor / element
		logic is_scan;    // search or order check with work to do
		logic scan_last;  // walk ends with this step
	} sts_t;
endpackage

[src/ocd_ctrl.sv]
// controller state machine of the ordered circular deque unit
// depends on ocd_pkg and the assertion macros
`include "ordered_circular_deque_unit_macros.svh"
module ocd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ocd_pkg::sts_t  sts,
	output ocd_pkg::cmd_t  cmd
);
	import ocd_pkg::*;

	state_t state_q, state_next;
	logic   out_valid_q;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_next = ST_DECODE;
			ST_DECODE: begin
				if (sts.is_scan) state_next = ST_SCAN;
				else if (sts.need_rd) state_next = ST_RD;
				else state_next = ST_DONE;
			end
			ST_RD:     state_next = ST_DONE;
			ST_SCAN:   if (sts.scan_last) state_next = ST_DONE;
			ST_DONE:   if (!out_valid_q || !out_stall) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE:   begin in_stall = 1'b0; cmd.latch = in_valid; end
			ST_DECODE: cmd.decode = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_DONE:   cmd.finish = !out_valid_q || !out_stall;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`OCD_ASSERT_NEXT(a_latch_decodes, cmd.latch, state_q == ST_DECODE)
	`OCD_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid)
	`OCD_ASSERT_IMPL(a_stall_busy, state_q != ST_IDLE, in_stall)
endmodule

[src/ocd_dp.sv]
// datapath of the ordered circular deque unit: store, pointers, flag, walk
// depends on ocd_pkg and the assertion macros
`include "ordered_circular_deque_unit_macros.svh"
module ocd_dp #(
	parameter int CAPACITY   = ocd_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ocd_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ocd_pkg::cmd_t               cmd,
	output ocd_pkg::sts_t               sts,
	input  logic [ocd_pkg::FUNC_W-1:0]  func,
	input  logic signed [ocd_pkg::VALUE_W-1:0] value,
	input  logic [ocd_pkg::POS_W-1:0]   position,
	output logic signed [ocd_pkg::VALUE_W-1:0] read_value,
	output logic [ocd_pkg::POS_W-1:0]   found_index,
	output logic                        found,
	output logic [ocd_pkg::LEN_W-1:0]   length,
	output logic [1:0]                  order_state,
	output logic [1:0]                  error
);
	import ocd_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	order_t        flag_q;

	logic [FUNC_W-1:0]            func_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [POS_W-1:0]             pos_q;
	err_t                         err_q;
	logic                         is_scan_q;

	logic [CW-1:0]                idx_q;   // logical index of data on rdata_q
	logic signed [DATA_WIDTH-1:0] rdata_q, prev_q;
	logic                         have_prev_q, asc_q, desc_q, fnd_q;
	logic [CW-1:0]                fidx_q;

	// address of a logical index, with wrap
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] l);
		logic [CW:0] s;
		begin
			s = {{(CW+1-AW){1'b0}}, f} + {1'b0, l};
			if (s >= {1'b0, CAP_C}) s = s - {1'b0, CAP_C};
			slot = s[AW-1:0];
		end
	endfunction

	// decode-time checks
	logic [CW-1:0] pos_ext;
	logic          full, empty, oor;
	err_t          err_d;
	logic          nrd_d, scan_d;
	assign pos_ext = CW'(pos_q);
	assign full  = count_q >= CAP_C;
	assign empty = count_q == '0;
	assign oor   = PW'(pos_q) >= PW'(count_q);
	always_comb begin
		err_d = ERR_OK;
		nrd_d = 1'b0;
		scan_d = 1'b0;
		case (func_q)
			F_PUSH_TAIL, F_PUSH_FRONT: begin
				if (full) err_d = ERR_FULL;
				else nrd_d = !empty;
			end
			F_POP_FRONT, F_POP_BACK: if (empty) err_d = ERR_EMPTY;
			F_READ:  if (oor) err_d = ERR_RANGE; else nrd_d = 1'b1;
			F_WRITE: if (oor) err_d = ERR_RANGE;
			F_CHECK, F_SEARCH: scan_d = !empty;
			default: ;
		endcase
	end

	// read address chosen per phase
	logic [AW-1:0] raddr;
	logic [CW-1:0] scan_next;
	assign scan_next = idx_q + CW'(1);
	always_comb begin
		raddr = slot(front_q, '0);
		if (cmd.decode) begin
			case (func_q)
				F_PUSH_TAIL: raddr = slot(front_q, count_q - CW'(1));
				F_READ:      raddr = slot(front_q, pos_ext);
				default:     raddr = front_q;
			endcase
		end else if (cmd.scan_step) begin
			raddr = slot(front_q, scan_next);
		end
	end

	logic scan_active_q; // rdata_q holds a valid walk element
	logic walk_end;
	assign walk_end = scan_active_q && (scan_next >= count_q || (func_q == F_SEARCH &&
		rdata_q == val_q));
	assign sts = '{need_rd: nrd_d, is_scan: scan_d, scan_last: walk_end};

	// store read, held until the next access phase
	always_ff @(posedge clk) begin
		if (cmd.decode || cmd.scan_step) rdata_q <= mem[raddr];
	end

	// item capture and walk bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			val_q  <= DATA_WIDTH'(value);
			pos_q  <= position;
		end
		if (cmd.decode) begin
			err_q <= err_d;
			is_scan_q <= scan_d;
			idx_q <= '0;
			have_prev_q <= 1'b0;
			asc_q <= 1'b1;
			desc_q <= 1'b1;
			fnd_q <= 1'b0;
			fidx_q <= '0;
		end
		if (cmd.scan_step && scan_active_q) begin
			idx_q <= scan_next;
			prev_q <= rdata_q;
			have_prev_q <= 1'b1;
			if (have_prev_q) begin
				if (prev_q < rdata_q) desc_q <= 1'b0;
				else if (prev_q > rdata_q) asc_q <= 1'b0;
			end
			if (func_q == F_SEARCH && rdata_q == val_q && !fnd_q) begin
				fnd_q <= 1'b1;
				fidx_q <= idx_q;
			end
		end
	end

	// the first walk step waits for the element fetched at decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_active_q <= 1'b0;
		else if (cmd.decode) scan_active_q <= 1'b1;
		else if (cmd.finish) scan_active_q <= 1'b0;
	end

	// commit state and write memory; results loaded at finish
	logic signed [DATA_WIDTH-1:0] nb;
	assign nb = rdata_q;
	always_ff @(posedge clk) begin
		if (cmd.finish && err_q == ERR_OK) begin
			case (func_q)
				F_PUSH_TAIL: if (count_q == '0) mem[0] <= val_q;
					else mem[slot(front_q, count_q)] <= val_q;
				F_PUSH_FRONT: if (count_q == '0) mem[0] <= val_q;
					else mem[(front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1)] <= val_q;
				F_WRITE: mem[slot(front_q, pos_ext)] <= val_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			flag_q  <= ORD_NONE;
		end else if (cmd.finish && err_q == ERR_OK) begin
			case (func_q)
				F_PUSH_TAIL, F_PUSH_FRONT: begin
					count_q <= count_q + CW'(1);
					if (count_q == '0) begin
						front_q <= '0;
						flag_q <= ORD_ASC;
					end else begin
						if (func_q == F_PUSH_FRONT)
							front_q <= (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
						if (func_q == F_PUSH_TAIL) begin
							if ((flag_q == ORD_ASC && val_q < nb) ||
								(flag_q == ORD_DESC && val_q > nb)) flag_q <= ORD_NONE;
						end else begin
							if ((flag_q == ORD_ASC && val_q > nb) ||
								(flag_q == ORD_DESC && val_q < nb)) flag_q <= ORD_NONE;
						end
					end
				end
				F_POP_FRONT: begin
					count_q <= count_q - CW'(1);
					front_q <= (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + AW'(1);
				end
				F_POP_BACK: count_q <= count_q - CW'(1);
				F_WRITE:    flag_q <= ORD_NONE;
				F_CHECK: begin
					if (!is_scan_q || asc_q) flag_q <= ORD_ASC;
					else if (desc_q) flag_q <= ORD_DESC;
					else flag_q <= ORD_NONE;
				end
				F_CLEAR: begin
					front_q <= '0;
					count_q <= '0;
					flag_q <= ORD_NONE;
				end
				default: ;
			endcase
		end
	end

	// result registers, loaded at finish together with the state commit
	logic load_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) load_q <= 1'b0;
		else load_q <= cmd.finish;
	end
	logic signed [VALUE_W-1:0] rv_q;
	logic [POS_W-1:0] fi_q;
	logic fo_q;
	err_t er_q;
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rv_q <= (func_q == F_READ && err_q == ERR_OK) ? VALUE_W'(rdata_q) : '0;
			er_q <= err_q;
			fi_q <= '0;
			fo_q <= 1'b0;
			if (func_q == F_SEARCH && is_scan_q && fnd_q) begin
				fi_q <= POS_W'(fidx_q);
				fo_q <= 1'b1;
			end
		end
	end
	assign read_value  = rv_q;
	assign found_index = fi_q;
	assign found       = fo_q;
	assign length      = LEN_W'(count_q);
	assign order_state = flag_q;
	assign error       = er_q;

	`OCD_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CAP_C)
	`OCD_ASSERT_NEXT(a_err_hold, load_q && err_q != ERR_OK, $stable(count_q) && $stable(front_q))
	`OCD_ASSERT_IMPL(a_flag_code, load_q && count_q == '0 && func_q == F_CLEAR,
		flag_q == ORD_NONE)
endmodule

[src/ordered_circular_deque_unit.sv]
// top level of the ordered circular deque unit
// depends on ocd_pkg, ocd_ctrl and ocd_dp
// The unit takes one operation at a time. Push, pop, read, write and clear
// pass through capture, decode with one store read, an access state for reads
// and for pushes onto a non-empty deque, and commit; a stalled result holds
// the unit in commit until it is taken. Search and order check walk the store
// through its single registered read port, one element per cycle; a search
// stops at the first match. No clearing pass is needed after reset.
module ordered_circular_deque_unit #(
	parameter int CAPACITY   = ocd_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ocd_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ocd_pkg::FUNC_W-1:0]  func,
	input  logic signed [ocd_pkg::VALUE_W-1:0] value,
	input  logic [ocd_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [ocd_pkg::VALUE_W-1:0] read_value,
	output logic [ocd_pkg::POS_W-1:0]   found_index,
	output logic                        found,
	output logic [ocd_pkg::LEN_W-1:0]   length,
	output logic [1:0]                  order_state,
	output logic [1:0]                  error
);
	import ocd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ocd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	// storage and arithmetic
	ocd_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .func(func),
		.value(value), .position(position), .read_value(read_value),
		.found_index(found_index), .found(found), .length(length),
		.order_state(order_state), .error(error)
	);
endmodule

[verif/ordered_circular_deque_unit_tb.sv]
// testbench for the ordered circular deque unit: directed and random operations
// checked against a behavioral deque model kept in the bench; depends on ocd_pkg
`timescale 1ns / 1ps
module ordered_circular_deque_unit_tb;
	import ocd_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	typedef struct {
		logic signed [31:0] read_value;
		logic [9:0]         found_index;
		logic               found;
		logic [10:0]        length;
		logic [1:0]         order_state;
		logic [1:0]         error;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] func = '0;
	logic signed [31:0] value = '0;
	logic [9:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] read_value;
	logic [9:0] found_index;
	logic found;
	logic [10:0] length;
	logic [1:0] order_state;
	logic [1:0] error;

	// bench copy of the deque state
	logic signed [31:0] slots [CAP];
	int unsigned head_ptr;
	int unsigned live_count;
	order_t order_now;

	deque_result_t pending_results[$];
	int mismatches = 0;
	int result_count = 0;
	int item_count;
	int stall_mode = 0;

	ordered_circular_deque_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .value(value), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .found_index(found_index), .found(found),
		.length(length), .order_state(order_state), .error(error)
	);

	always #5 clk = ~clk;

	// timeout guard
	initial begin
		#20ms;
		$display("ordered_circular_deque_unit_tb: done, errors");
		$finish;
	end

	function automatic int unsigned slot_of(int unsigned idx);
		return (head_ptr + idx) % CAP;
	endfunction

	// apply one operation to the bench deque and return the expected result
	function automatic deque_result_t deque_apply(logic [3:0] op, logic signed [31:0] v,
			logic [9:0] pos);
		deque_result_t r;
		logic signed [31:0] nb;
		logic asc, desc;
		r = '{default: '0};
		case (op)
			F_PUSH_TAIL, F_PUSH_FRONT: begin
				if (live_count >= CAP) begin
					r.error = ERR_FULL;
				end else begin
					if (live_count == 0) begin
						head_ptr = 0;
						slots[0] = v;
						order_now = ORD_ASC;
					end else if (op == F_PUSH_TAIL) begin
						nb = slots[slot_of(live_count - 1)];
						slots[slot_of(live_count)] = v;
						if (order_now == ORD_ASC && v < nb) order_now = ORD_NONE;
						else if (order_now == ORD_DESC && v > nb) order_now = ORD_NONE;
					end else begin
						nb = slots[slot_of(0)];
						head_ptr = (head_ptr + CAP - 1) % CAP;
						slots[head_ptr] = v;
						if (order_now == ORD_ASC && v > nb) order_now = ORD_NONE;
						else if (order_now == ORD_DESC && v < nb) order_now = ORD_NONE;
					end
					live_count++;
				end
			end
			F_POP_FRONT, F_POP_BACK: begin
				if (live_count == 0) begin
					r.error = ERR_EMPTY;
				end else begin
					if (op == F_POP_FRONT) head_ptr = (head_ptr + 1) % CAP;
					live_count--;
				end
			end
			F_READ: begin
				if (pos >= live_count) r.error = ERR_RANGE;
				else r.read_value = slots[slot_of(pos)];
			end
			F_WRITE: begin
				if (pos >= live_count) begin
					r.error = ERR_RANGE;
				end else begin
					slots[slot_of(pos)] = v;
					order_now = ORD_NONE;
				end
			end
			F_CHECK: begin
				asc = 1'b1;
				desc = 1'b1;
				for (int i = 0; i + 1 < live_count; i++) begin
					if (slots[slot_of(i)] < slots[slot_of(i + 1)]) desc = 1'b0;
					else if (slots[slot_of(i)] > slots[slot_of(i + 1)]) asc = 1'b0;
				end
				order_now = asc ? ORD_ASC : (desc ? ORD_DESC : ORD_NONE);
			end
			F_SEARCH: begin
				for (int i = 0; i < live_count; i++) begin
					if (slots[slot_of(i)] == v) begin
						r.found_index = 10'(i);
						r.found = 1'b1;
						break;
					end
				end
			end
			F_CLEAR: begin
				head_ptr = 0;
				live_count = 0;
				order_now = ORD_NONE;
			end
			default: ;
		endcase
		r.length = 11'(live_count);
		r.order_state = order_now;
		return r;
	endfunction

	// send one transfer, with a random gap before it now and then
	task automatic send_op(logic [3:0] op, logic signed [31:0] v, logic [9:0] pos);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		func = op;
		value = v;
		position = pos;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.insert(pending_results.size(), deque_apply(op, v, pos));
		item_count++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// receiver stall pattern: modes switch between none, light and heavy
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		deque_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
			end else begin
				e = pending_results.pop_front();
				if (read_value !== e.read_value || found_index !== e.found_index ||
						found !== e.found || length !== e.length ||
						order_state !== e.order_state || error !== e.error) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp rd=%0d idx=%0d f=%0b len=%0d ord=%0d err=%0d",
							e.read_value, e.found_index, e.found, e.length,
							e.order_state, e.error);
						$display("          got rd=%0d idx=%0d f=%0b len=%0d ord=%0d err=%0d",
							read_value, found_index, found, length, order_state, error);
					end
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 7) - 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] rand_pos();
		if (live_count > 0 && $urandom_range(0, 4) != 0)
			return 10'($urandom_range(0, live_count - 1));
		return 10'($urandom);
	endfunction

	// errors on empty, extremes, unused codes, order transitions
	task automatic test_directed();
		send_op(F_POP_FRONT, 0, 0);
		send_op(F_POP_BACK, 0, 0);
		send_op(F_READ, 0, 0);
		send_op(F_WRITE, 5, 0);
		send_op(F_CHECK, 0, 0);
		send_op(F_PUSH_TAIL, 32'sh80000000, 10'h3ff);
		send_op(F_PUSH_TAIL, 32'sh7fffffff, 0);
		send_op(F_PUSH_FRONT, 32'sh80000000, 0);
		send_op(F_PUSH_FRONT, 1, 0);
		send_op(F_READ, 0, 3);
		send_op(F_READ, 0, 4);
		send_op(F_READ, 0, 10'h3ff);
		send_op(F_SEARCH, 32'sh7fffffff, 0);
		send_op(F_SEARCH, 99, 0);
		send_op(F_CHECK, 0, 0);
		send_op(F_WRITE, -1, 1);
		send_op(F_POP_FRONT, 0, 0);
		send_op(4'd9, 0, 0);
		send_op(4'd15, -1, 10'h3ff);
		send_op(F_CLEAR, 0, 0);
		send_op(F_PUSH_FRONT, 7, 0);
		send_op(F_PUSH_FRONT, 9, 0);
		send_op(F_PUSH_TAIL, 3, 0);
		send_op(F_CHECK, 0, 0);
	endtask

	// fill to capacity, push past full, drain a little, then pop on empty
	task automatic test_full_empty();
		send_op(F_CLEAR, 0, 0);
		for (int i = 0; i < CAP; i++)
			send_op(($urandom_range(0, 1)) ? F_PUSH_TAIL : F_PUSH_FRONT, $urandom, 0);
		send_op(F_PUSH_TAIL, 1, 0);
		send_op(F_PUSH_FRONT, 1, 0);
		send_op(F_READ, 0, 10'h3ff);
		send_op(F_SEARCH, slots[slot_of(CAP - 1)], 0);
		send_op(F_CHECK, 0, 0);
		for (int i = 0; i < 4; i++)
			send_op(($urandom_range(0, 1)) ? F_POP_BACK : F_POP_FRONT, 0, 0);
		send_op(F_CLEAR, 0, 0);
		send_op(F_POP_BACK, 0, 0);
		send_op(F_POP_FRONT, 0, 0);
	endtask

	// random mix, with ordered runs so the order flag survives
	task automatic test_random(int n);
		logic [3:0] op;
		logic signed [31:0] base;
		int run_len;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_op(F_CLEAR, 0, 0);
				base = 32'($urandom_range(0, 1000));
				run_len = $urandom_range(2, 12);
				for (int j = 0; j < run_len; j++) begin
					base += 32'($urandom_range(0, 3));
					send_op(F_PUSH_TAIL, base, 0);
				end
				send_op(F_CHECK, 0, 0);
				continue;
			end
			op = 4'($urandom_range(0, 9));
			if (op == 9) op = 4'($urandom_range(9, 15));
			if (op == F_SEARCH && live_count > 0 && $urandom_range(0, 1))
				send_op(op, slots[slot_of($urandom_range(0, live_count - 1))], 0);
			else if (op == F_CLEAR && $urandom_range(0, 3) != 0)
				send_op(F_PUSH_TAIL, rand_word(), rand_pos());
			else
				send_op(op, rand_word(), rand_pos());
		end
	endtask

	initial begin
		int wait_cycles;
		item_count = 0;
		head_ptr = 0;
		live_count = 0;
		order_now = ORD_NONE;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_empty();
		test_random(60);
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (CAP + 20) @(posedge clk);
		$display("covered %0d operations and %0d results, including full, empty,", item_count,
			result_count);
		$display("out-of-range access, search, order check and unused codes");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ordered_circular_deque_unit_tb: done, clean");
		end else begin
			$display("ordered_circular_deque_unit_tb: done, errors");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+src
src/ocd_pkg.sv
src/ocd_ctrl.sv
src/ocd_dp.sv
src/ordered_circular_deque_unit.sv
verif/ordered_circular_deque_unit_tb.sv
